// ===== hw/rtl/nvt_pkg.sv =====
// nvt_pkg: shared widths, operation and status codes, and controller/datapath
// command and status structs for the named value table
// no dependencies
package nvt_pkg;

  localparam int unsigned KIND_W        = 3;
  localparam int unsigned NAME_LOW_W    = 64;
  localparam int unsigned NAME_HIGH_W   = 56;
  localparam int unsigned NAME_FULL_W   = NAME_LOW_W + NAME_HIGH_W;
  localparam int unsigned VALUE_W       = 64;
  localparam int unsigned USED_INDEX_W  = 8;
  localparam int unsigned STATUS_W      = 2;
  localparam int unsigned SLOT_W        = 3;
  localparam int unsigned AMOUNT_W      = 4;
  localparam int unsigned AMOUNT_MAX    = 15;

  localparam int unsigned ENTRIES_DEF    = 8;
  localparam int unsigned NAME_BYTES_DEF = 15;

  localparam logic [KIND_W-1:0] KIND_WRITE   = 3'd0;
  localparam logic [KIND_W-1:0] KIND_READ    = 3'd1;
  localparam logic [KIND_W-1:0] KIND_DELETE  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_COUNT   = 3'd3;
  localparam logic [KIND_W-1:0] KIND_NAME_AT = 3'd4;

  localparam logic [STATUS_W-1:0] STATUS_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_MISS = 2'd2;

  typedef struct packed {
    logic load;
    logic issue;
    logic commit;
  } nvt_cmd_t;

  typedef struct packed {
    logic issue_last;
  } nvt_stat_t;

endpackage

// ===== hw/rtl/nvt_ram.sv =====
// nvt_ram: generic single write port, single read port memory with
// registered read data; no dependencies
module nvt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 8
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/nvt_ctrl.sv =====
// nvt_ctrl: sequencer for the named value table, one scan of all slots
// per transaction; depends on nvt_pkg
module nvt_ctrl
  import nvt_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start_i,
  input  nvt_stat_t stat_i,
  output nvt_cmd_t  cmd_o,
  output logic      busy_o,
  output logic      done_o
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_LAST   = 2'd2;
  localparam logic [1:0] ST_COMMIT = 2'd3;

  logic [1:0] state_q, state_d;
  logic       done_q;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd_o.issue = 1'b1;
        if (stat_i.issue_last) begin
          state_d = ST_LAST;
        end
      end
      ST_LAST: begin
        state_d = ST_COMMIT;
      end
      ST_COMMIT: begin
        cmd_o.commit = 1'b1;
        state_d      = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= (state_q == ST_COMMIT);
    end
  end

  assign busy_o = (state_q != ST_IDLE);
  assign done_o = done_q;

`ifndef SYNTH
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o)
    else $error("accepted transaction did not raise busy");

  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe held longer than one cycle");

  a_scan_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN && stat_i.issue_last) |=> state_q == ST_LAST)
    else $error("scan did not end after last slot");
`endif

endmodule

// ===== hw/rtl/nvt_dpath.sv =====
// nvt_dpath: name normalization, slot scan, compare, valid bits, stores and
// result registers; depends on nvt_pkg and nvt_ram
module nvt_dpath
  import nvt_pkg::*;
#(
  parameter int unsigned ENTRIES    = ENTRIES_DEF,
  parameter int unsigned NAME_BYTES = NAME_BYTES_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  nvt_cmd_t                  cmd_i,
  output nvt_stat_t                 stat_o,
  input  logic [KIND_W-1:0]         kind_i,
  input  logic [NAME_LOW_W-1:0]     name_low_i,
  input  logic [NAME_HIGH_W-1:0]    name_high_i,
  input  logic signed [VALUE_W-1:0] value_in_i,
  input  logic [USED_INDEX_W-1:0]   used_index_i,
  output logic [STATUS_W-1:0]       status_o,
  output logic signed [VALUE_W-1:0] value_out_o,
  output logic [SLOT_W-1:0]         slot_o,
  output logic [AMOUNT_W-1:0]       amount_o,
  output logic [NAME_LOW_W-1:0]     found_name_low_o,
  output logic [NAME_HIGH_W-1:0]    found_name_high_o
);

  localparam int unsigned IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned CNT_W  = $clog2(ENTRIES + 1);
  localparam int unsigned NAME_W = 8 * NAME_BYTES;

  // transaction registers
  logic [KIND_W-1:0]       kind_q;
  logic [NAME_W-1:0]       key_q;
  logic [VALUE_W-1:0]      value_q;
  logic [USED_INDEX_W-1:0] want_q;

  // scan control
  logic [IDX_W-1:0] addr_q;
  logic [IDX_W-1:0] cmp_idx_q;
  logic             cmp_vld_q;
  logic [CNT_W-1:0] cnt_q;
  logic             hit_q;
  logic             free_found_q;
  logic [IDX_W-1:0] hit_slot_q;
  logic [IDX_W-1:0] free_slot_q;
  logic [NAME_W-1:0]  cap_name_q;
  logic [VALUE_W-1:0] cap_value_q;

  logic [ENTRIES-1:0] valid_q;

  logic [NAME_W-1:0]  key_norm;
  logic [NAME_W-1:0]  name_rdata;
  logic [VALUE_W-1:0] value_rdata;
  logic [AMOUNT_W-1:0] cap_len;
  logic               cmp_valid_bit;
  logic               lookup_kind;
  logic               hit_now;
  logic               free_now;
  logic               name_we;
  logic               value_we;
  logic [IDX_W-1:0]   waddr;
  logic [NAME_FULL_W-1:0] cap_name_full;

  logic [STATUS_W-1:0] res_status;
  logic [VALUE_W-1:0]  res_value;
  logic [SLOT_W-1:0]   res_slot;
  logic [AMOUNT_W-1:0] res_amount;
  logic [NAME_FULL_W-1:0] res_name;

  logic [STATUS_W-1:0] status_q;
  logic [VALUE_W-1:0]  value_out_q;
  logic [SLOT_W-1:0]   slot_q;
  logic [AMOUNT_W-1:0] amount_q;
  logic [NAME_FULL_W-1:0] found_name_q;

  // bytes after the first zero byte read as zero
  always_comb begin : norm_blk
    logic [NAME_FULL_W-1:0] raw;
    logic                   alive;
    raw      = {name_high_i, name_low_i};
    alive    = 1'b1;
    key_norm = '0;
    for (int i = 0; i < NAME_BYTES; i++) begin
      alive = alive & (raw[8*i +: 8] != 8'd0);
      if (alive) begin
        key_norm[8*i +: 8] = raw[8*i +: 8];
      end
    end
  end

  always_comb begin : len_blk
    logic alive;
    alive   = 1'b1;
    cap_len = '0;
    for (int i = 0; i < NAME_BYTES; i++) begin
      alive   = alive & (cap_name_q[8*i +: 8] != 8'd0);
      cap_len = cap_len + AMOUNT_W'(alive);
    end
  end

  assign stat_o.issue_last = (addr_q == IDX_W'(ENTRIES - 1));

  assign cmp_valid_bit = valid_q[cmp_idx_q];
  assign lookup_kind   = (kind_q == KIND_WRITE) || (kind_q == KIND_READ) ||
                         (kind_q == KIND_DELETE);
  assign hit_now  = cmp_vld_q && !hit_q && cmp_valid_bit &&
                    ((lookup_kind && (name_rdata == key_q)) ||
                     ((kind_q == KIND_NAME_AT) && (USED_INDEX_W'(cnt_q) == want_q)));
  assign free_now = cmp_vld_q && !free_found_q && !cmp_valid_bit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_q       <= '0;
      cmp_idx_q    <= '0;
      cmp_vld_q    <= 1'b0;
      cnt_q        <= '0;
      hit_q        <= 1'b0;
      free_found_q <= 1'b0;
    end else if (cmd_i.load) begin
      addr_q       <= '0;
      cmp_vld_q    <= 1'b0;
      cnt_q        <= '0;
      hit_q        <= 1'b0;
      free_found_q <= 1'b0;
    end else begin
      cmp_vld_q <= cmd_i.issue;
      if (cmd_i.issue) begin
        cmp_idx_q <= addr_q;
        addr_q    <= addr_q + 1'b1;
      end
      if (cmp_vld_q && cmp_valid_bit) begin
        cnt_q <= cnt_q + 1'b1;
      end
      if (hit_now) begin
        hit_q <= 1'b1;
      end
      if (free_now) begin
        free_found_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      kind_q  <= kind_i;
      key_q   <= key_norm;
      value_q <= value_in_i;
      want_q  <= used_index_i;
    end
    if (hit_now) begin
      hit_slot_q  <= cmp_idx_q;
      cap_name_q  <= name_rdata;
      cap_value_q <= value_rdata;
    end
    if (free_now) begin
      free_slot_q <= cmp_idx_q;
    end
  end

  // store update at commit
  assign value_we = cmd_i.commit && (kind_q == KIND_WRITE) && (hit_q || free_found_q);
  assign name_we  = value_we && !hit_q;
  assign waddr    = hit_q ? hit_slot_q : free_slot_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (name_we) begin
      valid_q[free_slot_q] <= 1'b1;
    end else if (cmd_i.commit && (kind_q == KIND_DELETE) && hit_q) begin
      valid_q[hit_slot_q] <= 1'b0;
    end
  end

  nvt_ram #(
    .WIDTH (NAME_W),
    .DEPTH (ENTRIES)
  ) u_name_ram (
    .clk_i   (clk_i),
    .we_i    (name_we),
    .waddr_i (waddr),
    .wdata_i (key_q),
    .raddr_i (addr_q),
    .rdata_o (name_rdata)
  );

  nvt_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (ENTRIES)
  ) u_value_ram (
    .clk_i   (clk_i),
    .we_i    (value_we),
    .waddr_i (waddr),
    .wdata_i (value_q),
    .raddr_i (addr_q),
    .rdata_o (value_rdata)
  );

  assign cap_name_full = NAME_FULL_W'(cap_name_q);

  always_comb begin
    res_status = STATUS_MISS;
    res_value  = '0;
    res_slot   = '0;
    res_amount = '0;
    res_name   = '0;
    unique case (kind_q)
      KIND_WRITE: begin
        if (hit_q) begin
          res_status = STATUS_OK;
          res_slot   = SLOT_W'(hit_slot_q);
        end else if (free_found_q) begin
          res_status = STATUS_OK;
          res_slot   = SLOT_W'(free_slot_q);
        end else begin
          res_status = STATUS_FULL;
        end
      end
      KIND_READ: begin
        if (hit_q) begin
          res_status = STATUS_OK;
          res_value  = cap_value_q;
          res_slot   = SLOT_W'(hit_slot_q);
        end
      end
      KIND_DELETE: begin
        if (hit_q) begin
          res_status = STATUS_OK;
          res_slot   = SLOT_W'(hit_slot_q);
        end
      end
      KIND_COUNT: begin
        res_status = STATUS_OK;
        res_amount = (32'(cnt_q) > AMOUNT_MAX) ? AMOUNT_W'(AMOUNT_MAX) : AMOUNT_W'(cnt_q);
      end
      KIND_NAME_AT: begin
        if (hit_q) begin
          res_status = STATUS_OK;
          res_slot   = SLOT_W'(hit_slot_q);
          res_amount = cap_len;
          res_name   = cap_name_full;
        end
      end
      default: begin
        res_status = STATUS_MISS;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      status_q     <= res_status;
      value_out_q  <= res_value;
      slot_q       <= res_slot;
      amount_q     <= res_amount;
      found_name_q <= res_name;
    end
  end

  assign status_o          = status_q;
  assign value_out_o       = value_out_q;
  assign slot_o            = slot_q;
  assign amount_o          = amount_q;
  assign found_name_low_o  = found_name_q[NAME_LOW_W-1:0];
  assign found_name_high_o = found_name_q[NAME_FULL_W-1:NAME_LOW_W];

`ifndef SYNTH
  a_hit_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.commit && hit_q) |-> valid_q[hit_slot_q])
    else $error("matched slot not valid at commit");

  a_delete_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.commit && kind_q == KIND_DELETE && hit_q) |=> !valid_q[$past(hit_slot_q)])
    else $error("delete left slot valid");

  a_full_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.commit && kind_q == KIND_WRITE && !hit_q && !free_found_q) |-> (&valid_q))
    else $error("table full reported with a free slot");
`endif

endmodule

// ===== hw/rtl/named_value_table_core.sv =====
// named_value_table_core: top level of the named value table
// depends on nvt_pkg, nvt_ctrl, nvt_dpath (and nvt_ram through nvt_dpath)
//
// channel   direction  handshake                         payload
// command   in         start_i, accepted when !busy_o    kind_i, name_low_i, name_high_i,
//                                                        value_in_i, used_index_i
// result    out        done_o, one cycle, no back-pressure status_o, value_out_o, slot_o,
//                                                        amount_o, found_name_low_o,
//                                                        found_name_high_o
//
// every transaction runs the scan, which reads one slot of the name and value memories
// per cycle, then passes through the last and commit states before done_o
// busy_o falls in the cycle that done_o is high, so a new transaction may be
// accepted in that cycle
// reset clears all valid bits at once; no clearing pass
// the receiver cannot stall results
module named_value_table_core
  import nvt_pkg::*;
#(
  parameter int unsigned ENTRIES    = ENTRIES_DEF,
  parameter int unsigned NAME_BYTES = NAME_BYTES_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  output logic                      busy_o,
  input  logic [KIND_W-1:0]         kind_i,
  input  logic [NAME_LOW_W-1:0]     name_low_i,
  input  logic [NAME_HIGH_W-1:0]    name_high_i,
  input  logic signed [VALUE_W-1:0] value_in_i,
  input  logic [USED_INDEX_W-1:0]   used_index_i,
  output logic                      done_o,
  output logic [STATUS_W-1:0]       status_o,
  output logic signed [VALUE_W-1:0] value_out_o,
  output logic [SLOT_W-1:0]         slot_o,
  output logic [AMOUNT_W-1:0]       amount_o,
  output logic [NAME_LOW_W-1:0]     found_name_low_o,
  output logic [NAME_HIGH_W-1:0]    found_name_high_o
);

  nvt_cmd_t  cmd;
  nvt_stat_t stat;

  nvt_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .stat_i  (stat),
    .cmd_o   (cmd),
    .busy_o  (busy_o),
    .done_o  (done_o)
  );

  nvt_dpath #(
    .ENTRIES    (ENTRIES),
    .NAME_BYTES (NAME_BYTES)
  ) u_dpath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .stat_o            (stat),
    .kind_i            (kind_i),
    .name_low_i        (name_low_i),
    .name_high_i       (name_high_i),
    .value_in_i        (value_in_i),
    .used_index_i      (used_index_i),
    .status_o          (status_o),
    .value_out_o       (value_out_o),
    .slot_o            (slot_o),
    .amount_o          (amount_o),
    .found_name_low_o  (found_name_low_o),
    .found_name_high_o (found_name_high_o)
  );

endmodule

// ===== test/named_value_table_core_tb.sv =====
`timescale 1ns / 100ps
// named_value_table_core_tb: self-checking testbench for the named value table
// depends on nvt_pkg and named_value_table_core; drives commands, predicts and checks replies
module named_value_table_core_tb;
  import nvt_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned POOL_SIZE   = 12;
  localparam int unsigned REPORT_MAX  = 40;

  localparam logic [KIND_W-1:0] KIND_SPARE_A = 3'd5;
  localparam logic [KIND_W-1:0] KIND_SPARE_C = 3'd7;

  typedef struct packed {
    logic [KIND_W-1:0]         kind;
    logic [NAME_FULL_W-1:0]    name;
    logic signed [VALUE_W-1:0] value;
    logic [USED_INDEX_W-1:0]   used_index;
  } table_op_t;

  typedef struct packed {
    logic [STATUS_W-1:0]       status;
    logic signed [VALUE_W-1:0] value;
    logic [SLOT_W-1:0]         slot;
    logic [AMOUNT_W-1:0]       amount;
    logic [NAME_LOW_W-1:0]     name_low;
    logic [NAME_HIGH_W-1:0]    name_high;
  } table_reply_t;

  logic                      clk_i;
  logic                      rst_ni = 1'b0;
  logic                      start_i = 1'b0;
  logic                      busy_o;
  logic [KIND_W-1:0]         kind_i = '0;
  logic [NAME_LOW_W-1:0]     name_low_i = '0;
  logic [NAME_HIGH_W-1:0]    name_high_i = '0;
  logic signed [VALUE_W-1:0] value_in_i = '0;
  logic [USED_INDEX_W-1:0]   used_index_i = '0;
  logic                      done_o;
  logic [STATUS_W-1:0]       status_o;
  logic signed [VALUE_W-1:0] value_out_o;
  logic [SLOT_W-1:0]         slot_o;
  logic [AMOUNT_W-1:0]       amount_o;
  logic [NAME_LOW_W-1:0]     found_name_low_o;
  logic [NAME_HIGH_W-1:0]    found_name_high_o;

  // shadow copy of the table
  logic                   shadow_used  [ENTRIES_DEF];
  logic [NAME_FULL_W-1:0] shadow_name  [ENTRIES_DEF];
  logic [VALUE_W-1:0]     shadow_value [ENTRIES_DEF];

  table_op_t              op_queue[$];
  table_reply_t           pending_replies[$];
  logic [NAME_FULL_W-1:0] name_pool [POOL_SIZE];
  int unsigned            mismatches = 0;
  int unsigned            cycles = 0;
  int unsigned            idle_left;
  int unsigned            sent;

  named_value_table_core DUT (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start_i          (start_i),
    .busy_o           (busy_o),
    .kind_i           (kind_i),
    .name_low_i       (name_low_i),
    .name_high_i      (name_high_i),
    .value_in_i       (value_in_i),
    .used_index_i     (used_index_i),
    .done_o           (done_o),
    .status_o         (status_o),
    .value_out_o      (value_out_o),
    .slot_o           (slot_o),
    .amount_o         (amount_o),
    .found_name_low_o (found_name_low_o),
    .found_name_high_o(found_name_high_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    for (int i = 0; i < ENTRIES_DEF; i++) begin
      shadow_used[i] = 1'b0;
    end
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  function automatic logic [VALUE_W-1:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic int unsigned name_length(input logic [NAME_FULL_W-1:0] raw);
    int unsigned n;
    n = 0;
    while (n < NAME_BYTES_DEF && raw[8*n +: 8] != 8'h00) n++;
    return n;
  endfunction

  function automatic logic [NAME_FULL_W-1:0] trim_name(input logic [NAME_FULL_W-1:0] raw);
    logic [NAME_FULL_W-1:0] kept;
    int unsigned            len;
    kept = '0;
    len = name_length(raw);
    for (int unsigned b = 0; b < len; b++) kept[8*b +: 8] = raw[8*b +: 8];
    return kept;
  endfunction

  // pool name with random bytes after the terminator half of the time
  function automatic logic [NAME_FULL_W-1:0] dress_name(input int unsigned idx);
    logic [NAME_FULL_W-1:0] raw;
    int unsigned            len;
    raw = name_pool[idx];
    len = name_length(raw);
    if ($urandom_range(0, 1) == 1) begin
      for (int unsigned b = len + 1; b < NAME_BYTES_DEF; b++) raw[8*b +: 8] = 8'($urandom);
    end
    return raw;
  endfunction

  // applies one transaction to the shadow table and returns the reply it must give
  function automatic table_reply_t apply_table_op(input table_op_t op);
    table_reply_t           r;
    logic [NAME_FULL_W-1:0] key;
    int                     hit;
    int                     free_slot;
    int unsigned            seen;
    int unsigned            used;
    r = '0;
    r.status = STATUS_MISS;
    key = trim_name(op.name);
    hit = -1;
    free_slot = -1;
    used = 0;
    for (int i = 0; i < ENTRIES_DEF; i++) begin
      if (hit < 0 && shadow_used[i] && shadow_name[i] == key) hit = i;
      if (free_slot < 0 && !shadow_used[i]) free_slot = i;
      if (shadow_used[i]) used++;
    end
    case (op.kind)
      KIND_WRITE: begin
        if (hit < 0 && free_slot >= 0) begin
          hit = free_slot;
          shadow_used[hit] = 1'b1;
          shadow_name[hit] = key;
        end
        if (hit >= 0) begin
          shadow_value[hit] = op.value;
          r.status = STATUS_OK;
          r.slot = SLOT_W'(hit);
        end else begin
          r.status = STATUS_FULL;
        end
      end
      KIND_READ: begin
        if (hit >= 0) begin
          r.status = STATUS_OK;
          r.value = shadow_value[hit];
          r.slot = SLOT_W'(hit);
        end
      end
      KIND_DELETE: begin
        if (hit >= 0) begin
          shadow_used[hit] = 1'b0;
          r.status = STATUS_OK;
          r.slot = SLOT_W'(hit);
        end
      end
      KIND_COUNT: begin
        r.status = STATUS_OK;
        r.amount = (used > AMOUNT_MAX) ? AMOUNT_W'(AMOUNT_MAX) : AMOUNT_W'(used);
      end
      KIND_NAME_AT: begin
        seen = 0;
        for (int i = 0; i < ENTRIES_DEF; i++) begin
          if (shadow_used[i]) begin
            if (seen == op.used_index && r.status == STATUS_MISS) begin
              r.status = STATUS_OK;
              r.slot = SLOT_W'(i);
              r.amount = AMOUNT_W'(name_length(shadow_name[i]));
              {r.name_high, r.name_low} = shadow_name[i];
            end
            seen++;
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic add_op(input logic [KIND_W-1:0] kind, input logic [NAME_FULL_W-1:0] name,
                        input logic [VALUE_W-1:0] value, input logic [USED_INDEX_W-1:0] idx);
    table_op_t op;
    op.kind = kind;
    op.name = name;
    op.value = value;
    op.used_index = idx;
    op_queue.push_back(op);
  endtask

  task automatic build_stimulus();
    int unsigned len;
    int unsigned pick;
    int unsigned write_cut;
    int unsigned delete_cut;
    logic [USED_INDEX_W-1:0] idx;
    // empty name, a full-length name, then names told apart by their first byte
    name_pool[0] = '0;
    name_pool[1] = '1;
    for (int unsigned p = 2; p < POOL_SIZE; p++) begin
      name_pool[p] = '0;
      name_pool[p][7:0] = 8'(p);
      len = $urandom_range(1, NAME_BYTES_DEF - 1);
      for (int unsigned b = 1; b < len; b++) name_pool[p][8*b +: 8] = 8'($urandom_range(1, 255));
    end

    // directed part
    add_op(KIND_COUNT, dress_name(2), rand64(), 8'd0);
    add_op(KIND_READ, dress_name(2), rand64(), 8'd0);
    add_op(KIND_DELETE, dress_name(2), rand64(), 8'd0);
    add_op(KIND_NAME_AT, dress_name(2), rand64(), 8'd0);
    add_op(KIND_WRITE, dress_name(0), 64'h7fff_ffff_ffff_ffff, 8'd0);
    add_op(KIND_WRITE, name_pool[1], 64'h8000_0000_0000_0000, 8'd0);
    for (int unsigned p = 2; p < ENTRIES_DEF; p++) add_op(KIND_WRITE, dress_name(p), rand64(), 8'd0);
    add_op(KIND_WRITE, dress_name(ENTRIES_DEF), rand64(), 8'd0);
    add_op(KIND_WRITE, dress_name(3), '1, 8'd0);
    add_op(KIND_READ, dress_name(3), rand64(), 8'd0);
    add_op(KIND_COUNT, '0, rand64(), 8'd0);
    add_op(KIND_NAME_AT, '1, rand64(), 8'd0);
    add_op(KIND_NAME_AT, '0, rand64(), 8'd1);
    add_op(KIND_NAME_AT, '0, rand64(), 8'(ENTRIES_DEF));
    add_op(KIND_NAME_AT, '0, rand64(), '1);
    add_op(KIND_DELETE, dress_name(4), rand64(), 8'd0);
    add_op(KIND_WRITE, dress_name(9), rand64(), 8'd0);
    add_op(KIND_READ, name_pool[0], rand64(), 8'd0);
    for (int k = KIND_SPARE_A; k <= KIND_SPARE_C; k++) add_op(KIND_W'(k), dress_name(5), rand64(), 8'd0);

    // random part, alternating write-heavy and read-heavy stretches
    for (int unsigned n = 0; n < 1625; n++) begin
      write_cut = ((n / 200) % 2 == 0) ? 40 : 20;
      delete_cut = ((n / 200) % 2 == 0) ? 68 : 70;
      pick = $urandom_range(0, 99);
      idx = ($urandom_range(0, 4) == 0) ? USED_INDEX_W'($urandom) :
                                          USED_INDEX_W'($urandom_range(0, ENTRIES_DEF + 1));
      if (pick < write_cut)
        add_op(KIND_WRITE, dress_name($urandom_range(0, POOL_SIZE - 1)), rand64(), idx);
      else if (pick < 60)
        add_op(KIND_READ, dress_name($urandom_range(0, POOL_SIZE - 1)), rand64(), idx);
      else if (pick < delete_cut)
        add_op(KIND_DELETE, dress_name($urandom_range(0, POOL_SIZE - 1)), rand64(), idx);
      else if (pick < 76)
        add_op(KIND_COUNT, dress_name($urandom_range(0, POOL_SIZE - 1)), rand64(), idx);
      else if (pick < 89)
        add_op(KIND_NAME_AT, dress_name($urandom_range(0, POOL_SIZE - 1)), rand64(), idx);
      else if (pick < 92)
        add_op(KIND_W'($urandom_range(KIND_SPARE_A, KIND_SPARE_C)), NAME_FULL_W'(rand64()),
               rand64(), idx);
      else
        add_op(KIND_W'($urandom), NAME_FULL_W'({rand64(), rand64()}), rand64(),
               USED_INDEX_W'($urandom));
    end
  endtask

  task automatic report_mismatch(input string what, input logic [127:0] got,
                                 input logic [127:0] want);
    mismatches++;
    if (mismatches <= REPORT_MAX)
      $display("%0t: %s mismatch: got %h, expected %h", $realtime, what, got, want);
  endtask

  // payload is scrambled during idle gaps between offered transactions
  task automatic scramble_payload();
    kind_i <= KIND_W'($urandom);
    name_low_i <= rand64();
    name_high_i <= NAME_HIGH_W'(rand64());
    value_in_i <= rand64();
    used_index_i <= USED_INDEX_W'($urandom);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : feed_ops
    table_op_t next_op;
    logic      taken;
    if (!rst_ni) begin
      start_i <= 1'b0;
      kind_i <= '0;
      name_low_i <= '0;
      name_high_i <= '0;
      value_in_i <= '0;
      used_index_i <= '0;
      idle_left <= 0;
      sent <= 0;
    end else begin
      taken = start_i && (busy_o === 1'b0);
      if (taken) sent <= sent + 1;
      if (start_i && !taken) begin
        // hold until accepted
      end else if (idle_left != 0) begin
        start_i <= 1'b0;
        idle_left <= idle_left - 1;
        scramble_payload();
      end else if (taken && op_queue.size() > 150 && (sent % 300) < 200 &&
                   $urandom_range(0, 2) == 0) begin
        start_i <= 1'b0;
        idle_left <= $urandom_range(0, 12);
        scramble_payload();
      end else if (op_queue.size() != 0) begin
        next_op = op_queue.pop_front();
        start_i <= 1'b1;
        kind_i <= next_op.kind;
        {name_high_i, name_low_i} <= next_op.name;
        value_in_i <= next_op.value;
        used_index_i <= next_op.used_index;
      end else begin
        start_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin : watch_replies
    table_reply_t want;
    table_op_t    seen_op;
    if (rst_ni) begin
      if (done_o === 1'b1) begin
        if (pending_replies.size() == 0) begin
          report_mismatch("unexpected transaction", 128'(status_o), '0);
        end else begin
          want = pending_replies.pop_front();
          if (status_o !== want.status)
            report_mismatch("status", 128'(status_o), 128'(want.status));
          if (value_out_o !== want.value)
            report_mismatch("value_out", 128'(value_out_o), 128'(want.value));
          if (slot_o !== want.slot)
            report_mismatch("slot", 128'(slot_o), 128'(want.slot));
          if (amount_o !== want.amount)
            report_mismatch("amount", 128'(amount_o), 128'(want.amount));
          if (found_name_low_o !== want.name_low)
            report_mismatch("found_name_low", 128'(found_name_low_o), 128'(want.name_low));
          if (found_name_high_o !== want.name_high)
            report_mismatch("found_name_high", 128'(found_name_high_o), 128'(want.name_high));
        end
      end
      if (start_i && busy_o === 1'b0) begin
        seen_op.kind = kind_i;
        seen_op.name = {name_high_i, name_low_i};
        seen_op.value = value_in_i;
        seen_op.used_index = used_index_i;
        pending_replies.push_back(apply_table_op(seen_op));
      end
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("FAIL named_value_table_core");
      $finish;
    end
  end

  initial begin
    build_stimulus();
    @(posedge clk_i);
    while (op_queue.size() != 0 || start_i || pending_replies.size() != 0) @(posedge clk_i);
    repeat (ENTRIES_DEF + 10) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("PASS named_value_table_core");
    end else begin
      $display("FAIL named_value_table_core");
    end
    $finish;
  end

endmodule
